>>> hdl/kwct_pkg.sv
// Shared constants for the keyed waiter count table.
`default_nettype none
package kwct_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 3;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_INC   = 2'd0;
  localparam cmd_t CMD_DEC   = 2'd1;
  localparam cmd_t CMD_QUERY = 2'd2;

  localparam status_t STAT_OK       = 3'd0;
  localparam status_t STAT_CREATED  = 3'd1;
  localparam status_t STAT_REMOVED  = 3'd2;
  localparam status_t STAT_NOTFOUND = 3'd3;
  localparam status_t STAT_FULL     = 3'd4;
  localparam status_t STAT_SAT      = 3'd5;

  localparam count_t COUNT_MAX  = 16'hFFFF;
  localparam count_t COUNT_ZERO = 16'd0;
  localparam count_t COUNT_ONE  = 16'd1;

endpackage
`default_nettype wire

>>> hdl/kwct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kwct_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hdl/keyed_waiter_count_table.sv
// Keyed waiter count table: top level with scan sequencer and slot storage.
// One request at a time: in_stall_o is high through scan and write-back. The slot RAM
//   is read one slot a cycle through a single key comparator; write-back updates the slot.
// The next input beat is taken while a finished result still waits in the output register.
// Reset (rst_ni low, async): all slots invalid, sequencer idle, no result pending.
`default_nettype none
module keyed_waiter_count_table #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire kwct_pkg::cmd_t    cmd_i,
  input  wire logic [31:0]       key_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output kwct_pkg::count_t       count_o,
  output kwct_pkg::status_t      status_o
);
  import kwct_pkg::*;

  // Stored key width: keys are 32-bit beats masked to KEY_BITS.
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int RW = KW + COUNT_W;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;

  logic [1:0]         state_q, state_d;
  cmd_t               cmd_q;
  logic [KW-1:0]      key_q;
  logic [CW-1:0]      cnt_q, cnt_d;          // next slot to read
  logic               rd_vld_q, rd_vld_d;    // RAM data valid this cycle
  logic [IW-1:0]      rd_idx_q;              // slot that the RAM data belongs to
  logic               hit_q, hit_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  count_t             hit_cnt_q, hit_cnt_d;
  logic               free_q, free_d;
  logic [IW-1:0]      free_idx_q, free_idx_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic               out_valid_q;
  count_t             count_q;
  status_t            status_q;

  logic               accept;
  logic               issue;
  logic               wb_go;
  logic [RW-1:0]      rdata;
  logic [KW-1:0]      rd_key;
  count_t             rd_cnt;
  logic               slot_v;

  // write-back results
  count_t             res_count;
  status_t            res_status;
  logic               wr_en;
  logic [IW-1:0]      wr_idx;
  count_t             wr_cnt;
  logic               set_v;
  logic               clr_v;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign issue  = (state_q == S_SCAN) && (cnt_q < CW'(ENTRIES));
  assign wb_go  = (state_q == S_WB) && (!out_valid_q || !out_stall_i);

  assign rd_key = rdata[RW-1:COUNT_W];
  assign rd_cnt = rdata[COUNT_W-1:0];
  assign slot_v = valid_q[rd_idx_q];

  // Key and count of every slot share one RAM word.
  kwct_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i ({key_q, wr_cnt}),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (rdata)
  );

  // Scan: one slot per cycle through the comparator; first match and first
  // free slot are latched.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_vld_d   = issue;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_cnt_d  = hit_cnt_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (rd_vld_q) begin
          if (slot_v && (rd_key == key_q) && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
            hit_cnt_d = rd_cnt;
          end
          if (!slot_v && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
          if (rd_idx_q == IW'(ENTRIES - 1)) begin
            state_d = S_WB;
          end
        end
      end
      S_WB: begin
        if (wb_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Write-back: saturating increment, decrement with removal, or lookup.
  always_comb begin
    res_count  = COUNT_ZERO;
    res_status = STAT_NOTFOUND;
    wr_en      = 1'b0;
    wr_idx     = hit_idx_q;
    wr_cnt     = hit_cnt_q;
    set_v      = 1'b0;
    clr_v      = 1'b0;
    unique case (cmd_q)
      CMD_INC: begin
        if (hit_q) begin
          if (hit_cnt_q == COUNT_MAX) begin
            res_status = STAT_SAT;
            res_count  = COUNT_MAX;
          end else begin
            wr_cnt     = hit_cnt_q + COUNT_ONE;
            wr_en      = wb_go;
            res_status = STAT_OK;
            res_count  = wr_cnt;
          end
        end else if (free_q) begin
          wr_idx     = free_idx_q;
          wr_cnt     = COUNT_ONE;
          wr_en      = wb_go;
          set_v      = wb_go;
          res_status = STAT_CREATED;
          res_count  = COUNT_ONE;
        end else begin
          res_status = STAT_FULL;
        end
      end
      CMD_DEC: begin
        if (hit_q) begin
          res_status = STAT_OK;
          if (hit_cnt_q != COUNT_ZERO) begin
            wr_cnt    = hit_cnt_q - COUNT_ONE;
            wr_en     = wb_go;
            res_count = wr_cnt;
            if (wr_cnt == COUNT_ZERO) begin
              clr_v      = wb_go;
              res_status = STAT_REMOVED;
            end
          end
        end
      end
      default: begin
        // query; the unused code behaves the same
        if (hit_q) begin
          res_status = STAT_OK;
          res_count  = hit_cnt_q;
        end
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (set_v) begin
      valid_d[wr_idx] = 1'b1;
    end
    if (clr_v) begin
      valid_d[wr_idx] = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
      valid_q  <= valid_d;
      if (wb_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      key_q <= key_i[KW-1:0];
    end
    rd_idx_q   <= cnt_q[IW-1:0];
    hit_idx_q  <= hit_idx_d;
    hit_cnt_q  <= hit_cnt_d;
    free_idx_q <= free_idx_d;
    if (wb_go) begin
      count_q  <= res_count;
      status_q <= res_status;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

endmodule
`default_nettype wire

>>> hdl/kwct_checker.sv
// Port-level assertions for the keyed waiter count table, bound to the top level.
`default_nettype none
module kwct_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire kwct_pkg::count_t  count_o,
  input wire kwct_pkg::status_t status_o
);
  import kwct_pkg::*;

  // Stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(count_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  // One request at a time: the beat after an accept is stalled.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken during scan");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= STAT_SAT)
    else $error("status code out of range");

  // Absent, full and removed report zero.
  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_NOTFOUND || status_o == STAT_FULL ||
                    status_o == STAT_REMOVED) |-> count_o == COUNT_ZERO)
    else $error("nonzero count with empty status");

  a_created_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_CREATED |-> count_o == COUNT_ONE)
    else $error("created slot count not one");

endmodule

bind keyed_waiter_count_table kwct_checker u_kwct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .count_o     (count_o),
  .status_o    (status_o)
);
`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the keyed waiter count table, checked against a table mirror.
module tb_top;
  import kwct_pkg::*;

  localparam int   TABLE_SLOTS   = 16;
  localparam int   POOL_KEYS     = 20;
  localparam int   RANDOM_REQS   = 850;
  localparam int   GAP_PCT       = 8;
  // A request scans every slot and then writes back, so a few scans cover any leftover work.
  localparam int   SETTLE_CYCLES = 2 * TABLE_SLOTS + 8;
  localparam int   RUN_LIMIT     = 2000000;
  // The unused command code; the block treats it as a query.
  localparam cmd_t CMD_SPARE     = 2'd3;

  // hold: the sender waits for every outstanding result before presenting this beat.
  // calm: no input gaps and no output stalls while this beat is in flight.
  typedef struct {
    cmd_t        op;
    logic [31:0] id;
    bit          hold;
    bit          calm;
  } request_t;

  typedef struct {
    count_t  cnt;
    status_t st;
  } reply_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  cmd_t        cmd_i       = CMD_INC;
  logic [31:0] key_i       = 32'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  count_t      count_o;
  status_t     status_o;

  keyed_waiter_count_table #(
    .ENTRIES (TABLE_SLOTS),
    .KEY_BITS(32)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .key_i      (key_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .count_o    (count_o),
    .status_o   (status_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Table mirror: what the block should hold, updated at each accepted request beat.
  // ---------------------------------------------------------------------------
  bit          slot_used [TABLE_SLOTS];
  logic [31:0] slot_id   [TABLE_SLOTS];
  count_t      slot_cnt  [TABLE_SLOTS];

  request_t    pending_requests[$];
  reply_t      due_results[$];
  logic [31:0] key_pool[POOL_KEYS];

  int          reqs_queued = 0;
  int          reqs_taken  = 0;
  int          failures    = 0;
  bit          req_taken   = 1'b0;
  bit          quiet_mode  = 1'b0;
  request_t    drive_item;
  reply_t      want;
  reply_t      got;

  // Apply one request to the mirror and return the result the block owes for it.
  task automatic apply_to_table(input cmd_t op, input logic [31:0] id,
                                output count_t cnt, output status_t st);
    int hit;
    int hole;
    hit  = -1;
    hole = -1;
    cnt  = COUNT_ZERO;
    st   = STAT_NOTFOUND;
    // Walk downward so the lowest matching slot and the lowest free slot win.
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_id[i] == id) hit = i;
      if (!slot_used[i]) hole = i;
    end
    case (op)
      CMD_INC: begin
        if (hit >= 0) begin
          // Saturate rather than wrap.
          if (slot_cnt[hit] == COUNT_MAX) begin
            st = STAT_SAT;
          end else begin
            slot_cnt[hit] = slot_cnt[hit] + COUNT_ONE;
            st = STAT_OK;
          end
          cnt = slot_cnt[hit];
        end else if (hole < 0) begin
          // Table full: request dropped, nothing changes.
          st = STAT_FULL;
        end else begin
          slot_used[hole] = 1'b1;
          slot_id[hole]   = id;
          slot_cnt[hole]  = COUNT_ONE;
          cnt = COUNT_ONE;
          st  = STAT_CREATED;
        end
      end
      CMD_DEC: begin
        if (hit >= 0) begin
          st = STAT_OK;
          // A live slot at zero cannot occur; if it did, it would stay as it is.
          if (slot_cnt[hit] != COUNT_ZERO) begin
            slot_cnt[hit] = slot_cnt[hit] - COUNT_ONE;
            if (slot_cnt[hit] == COUNT_ZERO) begin
              slot_used[hit] = 1'b0;
              st = STAT_REMOVED;
            end
          end
          cnt = slot_cnt[hit];
        end
      end
      default: begin
        // Query, and the spare code which behaves the same.
        if (hit >= 0) begin
          cnt = slot_cnt[hit];
          st  = STAT_OK;
        end
      end
    endcase
  endtask

  task automatic queue_request(input cmd_t op, input logic [31:0] id,
                               input bit hold, input bit calm);
    request_t r;
    r.op   = op;
    r.id   = id;
    r.hold = hold;
    r.calm = calm;
    pending_requests.push_back(r);
    reqs_queued++;
  endtask

  // Polled on the falling edge, away from the monitor's updates.
  task automatic wait_for_idle();
    while (reqs_taken != reqs_queued || due_results.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    req_taken = in_valid_i && !in_stall_o;
    if (req_taken) begin
      apply_to_table(cmd_i, key_i, want.cnt, want.st);
      due_results.push_back(want);
      reqs_taken++;
    end
    if (out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("result beat with none outstanding: count %0d status %0d", count_o, status_o);
        failures++;
      end else begin
        got = due_results.pop_front();
        if (count_o !== got.cnt) begin
          $error("count: expected %0d, actual %0d", got.cnt, count_o);
          failures++;
        end
        if (status_o !== got.st) begin
          $error("status: expected %0d, actual %0d", got.st, status_o);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A presented beat is held until taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (pending_requests.size() != 0 &&
            !(pending_requests[0].hold && due_results.size() != 0) &&
            (pending_requests[0].calm || $urandom_range(99, 0) >= GAP_PCT)) begin
          drive_item = pending_requests.pop_front();
          quiet_mode = drive_item.calm;
          cmd_i      <= drive_item.op;
          key_i      <= drive_item.id;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !quiet_mode && ($urandom_range(99, 0) < GAP_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed beats, then random traffic over a small key pool.
  // ---------------------------------------------------------------------------
  initial begin
    int          roll;
    logic [31:0] junk;
    bit          calm;

    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h0000_0000;
    for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = $urandom;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table: absent key on query and on decrement.
    queue_request(CMD_QUERY, 32'h0000_0000, 1'b0, 1'b0);
    queue_request(CMD_DEC,   32'hFFFF_FFFF, 1'b0, 1'b0);
    // Create both extreme keys, bump one, read it back, spare code as a query.
    queue_request(CMD_INC,   32'h0000_0000, 1'b0, 1'b0);
    queue_request(CMD_INC,   32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_request(CMD_INC,   32'h0000_0000, 1'b0, 1'b0);
    queue_request(CMD_QUERY, 32'h0000_0000, 1'b0, 1'b0);
    queue_request(CMD_SPARE, 32'h0000_0000, 1'b0, 1'b0);
    // Count down to removal, then the key is gone.
    queue_request(CMD_DEC,   32'h0000_0000, 1'b0, 1'b0);
    queue_request(CMD_DEC,   32'h0000_0000, 1'b0, 1'b0);
    queue_request(CMD_QUERY, 32'h0000_0000, 1'b0, 1'b0);
    // Fill every slot, hit the full case, free one slot and reuse it.
    for (int i = 2; i <= TABLE_SLOTS; i++) queue_request(CMD_INC, key_pool[i], 1'b0, 1'b0);
    queue_request(CMD_INC, key_pool[TABLE_SLOTS + 1], 1'b0, 1'b0);
    queue_request(CMD_DEC, key_pool[2], 1'b0, 1'b0);
    queue_request(CMD_INC, key_pool[TABLE_SLOTS + 1], 1'b0, 1'b0);

    // Random traffic. Pool keys outnumber slots so the table fills and drains often;
    // a stretch in the middle runs with no gaps or stalls. The first beat waits for
    // the directed results to drain.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      calm = (n >= 350 && n < 550);
      roll = $urandom_range(99, 0);
      junk = $urandom;
      if (roll < 40) begin
        queue_request(CMD_INC, key_pool[$urandom_range(POOL_KEYS - 1, 0)], n == 0, calm);
      end else if (roll < 75) begin
        queue_request(CMD_DEC, key_pool[$urandom_range(POOL_KEYS - 1, 0)], n == 0, calm);
      end else if (roll < 87) begin
        queue_request(CMD_QUERY, key_pool[$urandom_range(POOL_KEYS - 1, 0)], n == 0, calm);
      end else if (roll < 92) begin
        queue_request(CMD_SPARE, key_pool[$urandom_range(POOL_KEYS - 1, 0)], n == 0, calm);
      end else if (roll < 97) begin
        // Noise: an unknown key on anything but increment.
        queue_request(cmd_t'($urandom_range(3, 1)), junk, n == 0, calm);
      end else begin
        // Short-lived key: create then release, so stray keys do not clog the table.
        queue_request(CMD_INC, junk, n == 0, calm);
        queue_request(CMD_DEC, junk, 1'b0, calm);
      end
    end

    wait_for_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #RUN_LIMIT;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
